// File: rtl/core/hws_pkg.sv
// ----------------------------------------------------------------------------
// hws_pkg
// Shared constants for the heightfield wave shader: request kinds, CSR
// indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package hws_pkg;

   localparam int GRID_DIM_DEFAULT = 16;

   localparam int HEIGHT_W = 9;
   localparam int DIFF_W   = 10;
   localparam int STEP_W   = 6;
   localparam int SPACE_W  = 7;
   localparam int LOAD_W   = 7;
   localparam int IDX_W    = 6;
   localparam int RG_W     = 7;
   localparam int BLUE_W   = 8;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_SHADE = 2'd2;

   localparam logic [1:0] CSR_STEP_SIZE = 2'd0;
   localparam logic [1:0] CSR_SPACING_X = 2'd1;
   localparam logic [1:0] CSR_SPACING_Y = 2'd2;

   localparam logic [STEP_W-1:0]  STEP_RESET    = 6'd1;
   localparam logic [SPACE_W-1:0] SPACING_RESET = 7'd6;

   localparam int HEIGHT_MAX = 100;

endpackage

// File: rtl/core/heightfield_wave_shader.sv
// ----------------------------------------------------------------------------
// heightfield_wave_shader
// Heightfield grid in one synchronous RAM with per-point direction flags;
// ticks sweep the grid, loads write a point, shades return two facet colors.
// ----------------------------------------------------------------------------
// Load: one RAM write. Tick: one RAM read-modify-write per point through the
// single read port. Shade: four RAM reads, then the bit-serial divide and
// square root per facet. After reset a clearing pass zeroes the RAM before
// the first request is taken; CSR writes are taken throughout.
// ----------------------------------------------------------------------------
module heightfield_wave_shader #(
   parameter int GRID_DIM = hws_pkg::GRID_DIM_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_kind,
   input  logic [hws_pkg::IDX_W-1:0]          req_x_index,
   input  logic [hws_pkg::IDX_W-1:0]          req_y_index,
   input  logic [hws_pkg::LOAD_W-1:0]         req_load_height,
   input  logic                               req_load_falling,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hws_pkg::RG_W-1:0]           rsp_upper_red_green,
   output logic [hws_pkg::BLUE_W-1:0]         rsp_upper_blue,
   output logic [hws_pkg::RG_W-1:0]           rsp_lower_red_green,
   output logic [hws_pkg::BLUE_W-1:0]         rsp_lower_blue,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [hws_pkg::SPACE_W-1:0]        csr_wdata
);

   localparam int DEPTH = GRID_DIM * GRID_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HW    = hws_pkg::HEIGHT_W;
   localparam int DW    = hws_pkg::DIFF_W;

   typedef enum logic [2:0] {
      T_CLEAR, T_IDLE, T_TICK, T_READ, T_FACET, T_RESP
   } tstate_type;

   tstate_type state_ff;

   logic [HW:0] mem [DEPTH];
   logic [HW:0] rd_data_ff;

   logic [hws_pkg::STEP_W-1:0]  step_ff;
   logic [hws_pkg::SPACE_W-1:0] sx_ff, sy_ff;

   logic [AW:0]   sweep_ff;
   logic          rd_pend_ff;
   logic [AW-1:0] tick_addr_ff;
   logic [AW-1:0] base_ff;
   logic [2:0]    cnt_ff;
   logic signed [HW-1:0] h00_ff, h10_ff, h01_ff, h11_ff;
   logic          sel_ff;
   logic          fstart_ff;

   logic          rsp_valid_ff;
   logic [hws_pkg::RG_W-1:0]   urg_ff, lrg_ff, out_urg_ff, out_lrg_ff;
   logic [hws_pkg::BLUE_W-1:0] ub_ff, lb_ff, out_ub_ff, out_lb_ff;

   logic          accept;
   logic          load_ok, shade_ok;
   logic [AW-1:0] req_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [HW:0]   mem_wdata;

   logic signed [HW-1:0] cur_h;
   logic signed [DW-1:0] tick_sum;
   logic          tick_fall;
   logic signed [DW-1:0] diff_a, diff_b;
   logic          fdone;
   logic [hws_pkg::RG_W-1:0]   f_rg;
   logic [hws_pkg::BLUE_W-1:0] f_blue;

   assign req_ready = (state_ff == T_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_ok   = ({1'b0, req_x_index} < 7'(GRID_DIM)) &&
                      ({1'b0, req_y_index} < 7'(GRID_DIM));
   assign shade_ok  = ({1'b0, req_x_index} < 7'(GRID_DIM - 1)) &&
                      ({1'b0, req_y_index} < 7'(GRID_DIM - 1));
   assign req_addr  = AW'(int'(req_x_index) * GRID_DIM + int'(req_y_index));

   assign cur_h    = rd_data_ff[HW-1:0];
   assign tick_sum = rd_data_ff[HW] ?
                     (DW'(cur_h) - $signed(DW'({1'b0, step_ff}))) :
                     (DW'(cur_h) + $signed(DW'({1'b0, step_ff})));
   always_comb begin
      tick_fall = rd_data_ff[HW];
      if (tick_sum >= DW'(hws_pkg::HEIGHT_MAX)) tick_fall = 1'b1;
      else if (tick_sum <= 0)                    tick_fall = 1'b0;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = tick_addr_ff;
      mem_wdata = {tick_fall, tick_sum[HW-1:0]};
      mem_raddr = sweep_ff[AW-1:0];
      case (state_ff)
         T_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff[AW-1:0];
            mem_wdata = '0;
         end
         T_IDLE: begin
            mem_we    = accept && (req_kind == hws_pkg::KIND_LOAD) && load_ok;
            mem_waddr = req_addr;
            mem_wdata = {req_load_falling, 2'b00, req_load_height};
         end
         T_TICK: mem_we = rd_pend_ff;
         T_READ: begin
            case (cnt_ff)
               3'd0:    mem_raddr = base_ff;
               3'd1:    mem_raddr = base_ff + AW'(GRID_DIM);
               3'd2:    mem_raddr = base_ff + AW'(1);
               default: mem_raddr = base_ff + AW'(GRID_DIM + 1);
            endcase
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= hws_pkg::STEP_RESET;
         sx_ff   <= hws_pkg::SPACING_RESET;
         sy_ff   <= hws_pkg::SPACING_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hws_pkg::CSR_STEP_SIZE: step_ff <= csr_wdata[hws_pkg::STEP_W-1:0];
            hws_pkg::CSR_SPACING_X: sx_ff   <= csr_wdata;
            hws_pkg::CSR_SPACING_Y: sy_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign diff_a = sel_ff ? (DW'(h01_ff) - DW'(h11_ff)) : (DW'(h00_ff) - DW'(h10_ff));
   assign diff_b = sel_ff ? (DW'(h00_ff) - DW'(h01_ff)) : (DW'(h10_ff) - DW'(h11_ff));

   hws_facet u_facet (
      .clock     (clock),
      .reset     (reset),
      .start     (fstart_ff),
      .diff_a    (diff_a),
      .diff_b    (diff_b),
      .spacing_x (sx_ff),
      .spacing_y (sy_ff),
      .done      (fdone),
      .red_green (f_rg),
      .blue      (f_blue)
   );

   always_ff @(posedge clock) begin
      fstart_ff <= 1'b0;
      if (reset) begin
         state_ff     <= T_CLEAR;
         sweep_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            T_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (AW + 1)'(DEPTH - 1)) state_ff <= T_IDLE;
            end
            T_IDLE: begin
               sweep_ff   <= '0;
               rd_pend_ff <= 1'b0;
               if (accept) begin
                  if (req_kind == hws_pkg::KIND_TICK) begin
                     state_ff <= T_TICK;
                  end else if (req_kind == hws_pkg::KIND_SHADE && shade_ok) begin
                     base_ff  <= req_addr;
                     cnt_ff   <= '0;
                     state_ff <= T_READ;
                  end
               end
            end
            T_TICK: begin
               rd_pend_ff   <= (sweep_ff < (AW + 1)'(DEPTH));
               tick_addr_ff <= sweep_ff[AW-1:0];
               if (sweep_ff < (AW + 1)'(DEPTH)) sweep_ff <= sweep_ff + 1'b1;
               else if (!rd_pend_ff) state_ff <= T_IDLE;
            end
            T_READ: begin
               cnt_ff <= cnt_ff + 3'd1;
               case (cnt_ff)
                  3'd1: h00_ff <= rd_data_ff[HW-1:0];
                  3'd2: h10_ff <= rd_data_ff[HW-1:0];
                  3'd3: h01_ff <= rd_data_ff[HW-1:0];
                  3'd4: h11_ff <= rd_data_ff[HW-1:0];
                  default: ;
               endcase
               if (cnt_ff == 3'd4) begin
                  sel_ff    <= 1'b0;
                  fstart_ff <= 1'b1;
                  state_ff  <= T_FACET;
               end
            end
            T_FACET: begin
               if (fdone) begin
                  if (!sel_ff) begin
                     urg_ff    <= f_rg;
                     ub_ff     <= f_blue;
                     sel_ff    <= 1'b1;
                     fstart_ff <= 1'b1;
                  end else begin
                     lrg_ff   <= f_rg;
                     lb_ff    <= f_blue;
                     state_ff <= T_RESP;
                  end
               end
            end
            T_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  out_urg_ff   <= urg_ff;
                  out_ub_ff    <= ub_ff;
                  out_lrg_ff   <= lrg_ff;
                  out_lb_ff    <= lb_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_upper_red_green = out_urg_ff;
   assign rsp_upper_blue      = out_ub_ff;
   assign rsp_lower_red_green = out_lrg_ff;
   assign rsp_lower_blue      = out_lb_ff;

endmodule

// File: rtl/core/hws_facet.sv
// ----------------------------------------------------------------------------
// hws_facet
// Shades one facet: builds the normal, divides nz^2 * 2^32 by |n|^2 one bit
// per cycle, takes the square root one bit per cycle and scales the Q1.16
// intensity to red/green and blue levels.
// ----------------------------------------------------------------------------
module hws_facet (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [hws_pkg::DIFF_W-1:0]    diff_a,
   input  logic signed [hws_pkg::DIFF_W-1:0]    diff_b,
   input  logic        [hws_pkg::SPACE_W-1:0]   spacing_x,
   input  logic        [hws_pkg::SPACE_W-1:0]   spacing_y,
   output logic                                 done,
   output logic        [hws_pkg::RG_W-1:0]      red_green,
   output logic        [hws_pkg::BLUE_W-1:0]    blue
);

   typedef enum logic [2:0] {
      F_IDLE, F_MUL1, F_MUL2, F_SUM, F_DIV, F_SQRT, F_COLOR
   } fstate_type;

   fstate_type state_ff;
   logic signed [hws_pkg::DIFF_W-1:0] da_ff, db_ff;
   logic signed [17:0] nx_ff, ny_ff;
   logic [13:0] nz_ff;
   logic [29:0] sqx_ff, sqy_ff;
   logic [27:0] sqz_ff;
   logic [31:0] len2_ff;
   logic [32:0] rem_ff, quo_ff;
   logic [5:0]  cnt_ff;
   logic [16:0] root_ff;
   logic [4:0]  bit_ff;
   logic        done_ff;
   logic [hws_pkg::RG_W-1:0]   rg_ff;
   logic [hws_pkg::BLUE_W-1:0] blue_ff;

   logic signed [17:0] nx_in, ny_in;
   logic signed [35:0] px, py;
   logic [27:0] pz;
   logic [32:0] div_t;
   logic [16:0] cand;
   logic [33:0] cand_sq;
   logic [17:0] qsum;
   logic [16:0] inten;
   logic [23:0] rg_prod;
   logic [24:0] blue_prod;

   assign nx_in   = $signed({1'b0, spacing_y}) * da_ff;
   assign ny_in   = $signed({1'b0, spacing_x}) * db_ff;
   assign px      = nx_ff * nx_ff;
   assign py      = ny_ff * ny_ff;
   assign pz      = nz_ff * nz_ff;
   assign div_t   = (cnt_ff == 6'd0) ? rem_ff : {rem_ff[31:0], 1'b0};
   assign cand    = root_ff | (17'd1 << bit_ff);
   assign cand_sq = cand * cand;
   assign qsum    = {1'b0, root_ff} + 18'd65536;
   assign inten   = qsum[17:1];
   assign rg_prod   = 24'(inten) * 24'd100;
   assign blue_prod = 25'(inten) * 25'd255;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  da_ff    <= diff_a;
                  db_ff    <= diff_b;
                  state_ff <= F_MUL1;
               end
            end
            F_MUL1: begin
               nx_ff    <= nx_in;
               ny_ff    <= ny_in;
               nz_ff    <= spacing_x * spacing_y;
               state_ff <= F_MUL2;
            end
            F_MUL2: begin
               sqx_ff   <= px[29:0];
               sqy_ff   <= py[29:0];
               sqz_ff   <= pz;
               state_ff <= F_SUM;
            end
            F_SUM: begin
               len2_ff  <= 32'(sqx_ff) + 32'(sqy_ff) + 32'(sqz_ff);
               rem_ff   <= 33'(sqz_ff);
               quo_ff   <= '0;
               cnt_ff   <= '0;
               root_ff  <= '0;
               bit_ff   <= 5'd16;
               state_ff <= (nz_ff == '0) ? F_COLOR : F_DIV;
            end
            F_DIV: begin
               if (div_t >= {1'b0, len2_ff}) begin
                  rem_ff <= div_t - {1'b0, len2_ff};
                  quo_ff <= {quo_ff[31:0], 1'b1};
               end else begin
                  rem_ff <= div_t;
                  quo_ff <= {quo_ff[31:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd32) state_ff <= F_SQRT;
            end
            F_SQRT: begin
               if (cand_sq <= {1'b0, quo_ff}) root_ff <= cand;
               bit_ff <= bit_ff - 5'd1;
               if (bit_ff == 5'd0) state_ff <= F_COLOR;
            end
            F_COLOR: begin
               rg_ff    <= rg_prod[22:16];
               blue_ff  <= blue_prod[23:16];
               done_ff  <= 1'b1;
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign done      = done_ff;
   assign red_green = rg_ff;
   assign blue      = blue_ff;

endmodule
